/* rtl/befs_pkg.sv */
package befs_pkg;

    // prefix and depth limits
    localparam int PREFIX_LEN = 7;
    localparam int MAX_DEPTH  = 255;

    // queue between classifier and emitter, depth a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // special characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // field codes
    localparam logic [1:0] FLD_LABEL = 2'd0;
    localparam logic [1:0] FLD_ITEM  = 2'd1;
    localparam logic [1:0] FLD_LONG  = 2'd2;
    localparam logic [1:0] FLD_TRAIL = 2'd3;

    typedef enum logic [2:0] {
        PH_PREFIX     = 3'd0,
        PH_LABEL      = 3'd1,
        PH_SKIP_ITEM  = 3'd2,
        PH_ITEM       = 3'd3,
        PH_SKIP_LONG  = 3'd4,
        PH_LONG       = 3'd5,
        PH_TRAIL      = 3'd6,
        PH_SKIP_TRAIL = 3'd7
    } t_phase;

    // one classified request: optional character result, optional closing result
    typedef struct packed {
        logic       has_char;
        logic [7:0] ch;
        logic [1:0] field;
        logic       has_close;
        logic       parse_error;
        logic       item_from_label;
    } t_entry;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

/* rtl/befs_front.sv */
module befs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    input  logic              i_q_full,
    output logic              o_push,
    output befs_pkg::t_entry  o_entry
);

    befs_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_prefix, n_prefix;
    logic [7:0]       r_depth, n_depth;
    logic [7:0]       r_prev, n_prev;
    logic             r_item_seen, n_item_seen;

    befs_pkg::t_phase w_phase_step;
    logic             w_item_step;
    logic             w_accept;
    logic             w_ws;
    logic             w_esc;
    logic             w_in_field;
    logic [1:0]       w_field;
    logic [7:0]       w_depth_inc;
    logic [7:0]       w_depth_new;
    logic             w_brace_end;
    logic             w_term;
    logic             w_emit;
    logic             w_prefix_done;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // classify the character against the current phase
    always_comb begin
        w_ws  = befs_pkg::is_ws(i_ch);
        w_esc = (r_prev == befs_pkg::CH_BSLASH);
        case (r_phase)
            befs_pkg::PH_LABEL: begin
                w_in_field = 1'b1;
                w_field    = befs_pkg::FLD_LABEL;
            end
            befs_pkg::PH_SKIP_ITEM: begin
                w_in_field = !w_ws;
                w_field    = befs_pkg::FLD_ITEM;
            end
            befs_pkg::PH_ITEM: begin
                w_in_field = 1'b1;
                w_field    = befs_pkg::FLD_ITEM;
            end
            befs_pkg::PH_SKIP_LONG: begin
                w_in_field = !w_ws;
                w_field    = befs_pkg::FLD_LONG;
            end
            befs_pkg::PH_LONG: begin
                w_in_field = 1'b1;
                w_field    = befs_pkg::FLD_LONG;
            end
            default: begin
                w_in_field = 1'b0;
                w_field    = befs_pkg::FLD_TRAIL;
            end
        endcase
        w_depth_inc = r_depth;
        if (i_ch == befs_pkg::CH_LBRACE && !w_esc && r_depth < 8'(befs_pkg::MAX_DEPTH)) begin
            w_depth_inc = r_depth + 8'd1;
        end
        w_depth_new = w_depth_inc;
        if (i_ch == befs_pkg::CH_RBRACE && !w_esc && w_depth_inc != 8'd0) begin
            w_depth_new = w_depth_inc - 8'd1;
        end
        w_brace_end   = (i_ch == befs_pkg::CH_RBRACE) && (w_depth_new == 8'd0);
        w_term        = w_in_field && (w_brace_end || i_ch == befs_pkg::CH_COMMA);
        w_emit        = (w_in_field && !w_term) || (r_phase == befs_pkg::PH_TRAIL)
                        || (r_phase == befs_pkg::PH_SKIP_TRAIL && !w_ws);
        w_prefix_done = ({1'b0, r_prefix} + 4'd1) >= 4'(befs_pkg::PREFIX_LEN);
    end

    // next state
    always_comb begin
        w_phase_step = r_phase;
        w_item_step  = r_item_seen;
        n_prefix     = r_prefix;
        n_depth      = r_depth;
        case (r_phase)
            befs_pkg::PH_PREFIX: begin
                if (w_prefix_done) begin
                    w_phase_step = befs_pkg::PH_LABEL;
                end else begin
                    n_prefix = r_prefix + 3'd1;
                end
            end
            befs_pkg::PH_SKIP_TRAIL: begin
                if (!w_ws) begin
                    w_phase_step = befs_pkg::PH_TRAIL;
                end
            end
            befs_pkg::PH_TRAIL: begin
                w_phase_step = r_phase;
            end
            default: begin
                if (w_in_field) begin
                    n_depth = w_depth_new;
                    if (w_term) begin
                        if (w_brace_end) begin
                            w_phase_step = (w_field == befs_pkg::FLD_LONG) ?
                                           befs_pkg::PH_TRAIL : befs_pkg::PH_SKIP_TRAIL;
                        end else if (w_field == befs_pkg::FLD_LABEL) begin
                            w_phase_step = befs_pkg::PH_SKIP_ITEM;
                        end else if (w_field == befs_pkg::FLD_ITEM) begin
                            w_phase_step = befs_pkg::PH_SKIP_LONG;
                        end else begin
                            w_phase_step = befs_pkg::PH_TRAIL;
                        end
                    end else begin
                        if (r_phase == befs_pkg::PH_SKIP_ITEM) begin
                            w_phase_step = befs_pkg::PH_ITEM;
                        end
                        if (r_phase == befs_pkg::PH_SKIP_LONG) begin
                            w_phase_step = befs_pkg::PH_LONG;
                        end
                        if (w_field == befs_pkg::FLD_ITEM) begin
                            w_item_step = 1'b1;
                        end
                    end
                end
            end
        endcase
        n_phase     = w_phase_step;
        n_item_seen = w_item_step;
        n_prev      = i_ch;
        // end of entry: everything back to the reset values
        if (i_last) begin
            n_phase     = befs_pkg::PH_PREFIX;
            n_prefix    = 3'd0;
            n_depth     = 8'd1;
            n_prev      = 8'd0;
            n_item_seen = 1'b0;
        end
    end

    // request to the queue
    always_comb begin
        o_push                  = w_accept && (w_emit || i_last);
        o_entry.has_char        = w_emit;
        o_entry.ch              = i_ch;
        o_entry.field           = w_field;
        o_entry.has_close       = i_last;
        o_entry.parse_error     = !(w_phase_step == befs_pkg::PH_TRAIL
                                    || w_phase_step == befs_pkg::PH_SKIP_TRAIL);
        o_entry.item_from_label = !o_entry.parse_error && !w_item_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= befs_pkg::PH_PREFIX;
            r_prefix    <= 3'd0;
            r_depth     <= 8'd1;
            r_prev      <= 8'd0;
            r_item_seen <= 1'b0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_prefix    <= n_prefix;
            r_depth     <= n_depth;
            r_prev      <= n_prev;
            r_item_seen <= n_item_seen;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_phase == befs_pkg::PH_PREFIX && r_depth == 8'd1
                                  && !r_item_seen))
        else $error("entry end did not restore the start state");

    a_prefix_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == befs_pkg::PH_PREFIX) |-> (r_depth == 8'd1 && !r_item_seen))
        else $error("depth or item flag changed during prefix");

endmodule

/* rtl/befs_queue.sv */
module befs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  befs_pkg::t_entry  i_entry,
    output logic              o_full,
    output logic              o_valid,
    output befs_pkg::t_entry  o_entry,
    input  logic              i_pop
);

    befs_pkg::t_entry              r_mem [befs_pkg::Q_DEPTH];
    logic [befs_pkg::Q_AW-1:0]     r_wr, r_rd;
    logic [befs_pkg::Q_CW-1:0]     r_count;

    // full is taken from the count alone so the two sides stay apart
    assign o_full  = (r_count == befs_pkg::Q_CW'(befs_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // pointers wrap on their own since the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + befs_pkg::Q_CW'(i_push) - befs_pkg::Q_CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= befs_pkg::Q_CW'(befs_pkg::Q_DEPTH)) && !(i_push && o_full)
        && !(i_pop && !o_valid))
        else $error("queue overflow or underflow");

endmodule

/* rtl/befs_back.sv */
module befs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  befs_pkg::t_entry  i_entry,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [15:0]       o_tdata,
    output logic [2:0]        o_tuser,
    output logic              o_tlast
);

    logic r_char_done, n_char_done;
    logic w_char_res;
    logic w_take;

    // character result goes first, closing result after it
    assign w_char_res = i_entry.has_char && !r_char_done;
    assign w_take     = i_valid && i_tready;

    always_comb begin
        o_tvalid = i_valid;
        o_tlast  = !w_char_res || !i_entry.has_close;
        if (w_char_res) begin
            o_tdata = {6'd0, 1'b0, 1'b0, i_entry.ch};
            o_tuser = {1'b0, i_entry.field};
        end else begin
            o_tdata = {6'd0, i_entry.item_from_label, i_entry.parse_error, 8'd0};
            o_tuser = {1'b1, befs_pkg::FLD_LABEL};
        end
        o_pop       = w_take && o_tlast;
        n_char_done = w_take ? (w_char_res && i_entry.has_close) : r_char_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_done <= 1'b0;
        end else begin
            r_char_done <= n_char_done;
        end
    end

    a_split_only_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_done |-> (i_valid && i_entry.has_char && i_entry.has_close))
        else $error("second half of a request without a pending closing result");

endmodule

/* rtl/brace_aware_entry_field_splitter.sv */
// each accepted character request is registered in the queue before its result is offered
// throughput: one character per cycle while the queue is not full; a last character that
//   also yields a field character gives two results, absorbed by a four-entry queue
// the input stalls only when that queue is full; the output side never waits on input
// reset (i_rst_n low at a clock edge) empties the queue, returns to prefix skipping,
//   depth one, previous character and item flag cleared
module brace_aware_entry_field_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,   // last character of the entry
    // results out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] ch_out, [8] parse_error,
                                          // [9] item_from_label, [15:10] zero
    output logic [2:0]  o_m_axis_tuser,   // [1:0] field, [2] closing
    output logic        o_m_axis_tlast    // last result of this character
);

    logic             w_push;
    logic             w_full;
    logic             w_q_valid;
    logic             w_pop;
    befs_pkg::t_entry w_push_entry;
    befs_pkg::t_entry w_head_entry;

    // front: prefix skip, brace depth, phase tracking and classification
    befs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_ch     (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // classified requests waiting for the output side
    befs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry),
        .i_pop   (w_pop)
    );

    // back: turns each request into one or two results
    befs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_entry  (w_head_entry),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
